// File: design/bpf_pkg.sv
// ----------------------------------------------------------------------------
// bpf_pkg
// Types and constants for the byte pipe with open-end counts.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int DEPTH    = 4096;
  localparam int MAX_ENDS = 255;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int FILL_W   = 13;
  localparam int END_W    = 8;

  typedef enum logic [2:0] {
    K_OPEN         = 3'd0,
    K_WRITE        = 3'd1,
    K_READ         = 3'd2,
    K_ADD_READER   = 3'd3,
    K_ADD_WRITER   = 3'd4,
    K_CLOSE_READER = 3'd5,
    K_CLOSE_WRITER = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EOF    = 2'd1,
    ST_BROKEN = 2'd2,
    ST_BLOCK  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_in;
    logic       request_end;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        data_out;
    logic [FILL_W-1:0] fill_level;
    logic              read_ready;
    logic              write_ready;
    logic              hang_up;
    logic              read_would_block;
    logic              pipe_in_use;
    logic              request_done;
  } out_item_t;

endpackage

// File: design/byte_pipe_fifo_with_end_counts.sv
// ----------------------------------------------------------------------------
// byte_pipe_fifo_with_end_counts
// Byte pipe: ring buffer with open read-end and write-end counts.
// ----------------------------------------------------------------------------
// The pipe takes one item per cycle, back to back, as long as the output side
// keeps up. Each item touches at most one ring entry, so the single-port ring
// memory (one read or one write per cycle, with a registered read) sets the
// rate; the result of an item is held in the middle stage while the ring
// read completes, then moves to the output register. Pointers, fill level and
// end counts are updated at the transfer, so a read right after a write sees
// the new byte. The ring needs no clearing pass after reset: only entries
// written since the last open or reset are read.
module byte_pipe_fifo_with_end_counts (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpf_pkg::out_item_t out_data
);
  import bpf_pkg::*;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
  localparam logic [ADDR_W-1:0] POS_LAST  = ADDR_W'(DEPTH - 1);
  localparam logic [END_W-1:0]  END_MAX   = END_W'(MAX_ENDS);
  localparam logic [END_W-1:0]  END_ONE   = END_W'(1);

  // ring storage
  logic [7:0] ring [DEPTH];
  logic [7:0] rd_data;

  // pipe state
  logic [ADDR_W-1:0] wr_pos, wr_pos_next;
  logic [ADDR_W-1:0] rd_pos, rd_pos_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [END_W-1:0]  readers, readers_next;
  logic [END_W-1:0]  writers, writers_next;
  logic              alloc, alloc_next;

  // middle stage and output register
  logic      s1_valid;
  out_item_t s1_res;
  logic      s1_rd_ok;
  out_item_t s1_out;
  out_item_t res_next;
  logic      rd_ok_next;
  logic      mem_we;
  logic      mem_re;
  status_t   status;

  logic accept;
  logic s1_move;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  // decode the item and work out the next pipe state
  always_comb begin
    wr_pos_next  = wr_pos;
    rd_pos_next  = rd_pos;
    fill_next    = fill;
    readers_next = readers;
    writers_next = writers;
    alloc_next   = alloc;
    status       = ST_OK;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    rd_ok_next   = 1'b0;
    case (in_data.kind)
      K_OPEN: begin
        wr_pos_next  = '0;
        rd_pos_next  = '0;
        fill_next    = '0;
        readers_next = END_ONE;
        writers_next = END_ONE;
        alloc_next   = 1'b1;
      end
      K_WRITE: begin
        if (readers == '0) begin
          status = ST_BROKEN;
        end else if (fill >= FILL_FULL) begin
          status = ST_BLOCK;
        end else begin
          mem_we      = 1'b1;
          wr_pos_next = (wr_pos == POS_LAST) ? '0 : wr_pos + 1'b1;
          fill_next   = fill + 1'b1;
        end
      end
      K_READ: begin
        if (fill != '0) begin
          mem_re      = 1'b1;
          rd_ok_next  = 1'b1;
          rd_pos_next = (rd_pos == POS_LAST) ? '0 : rd_pos + 1'b1;
          fill_next   = fill - 1'b1;
        end else if (writers == '0) begin
          status = ST_EOF;
        end else begin
          status = ST_BLOCK;
        end
      end
      K_ADD_READER: begin
        readers_next = (readers >= END_MAX) ? END_MAX : readers + 1'b1;
      end
      K_ADD_WRITER: begin
        writers_next = (writers >= END_MAX) ? END_MAX : writers + 1'b1;
      end
      K_CLOSE_READER: begin
        if (readers != '0) begin
          readers_next = readers - 1'b1;
          if (readers == END_ONE && writers == '0) begin
            alloc_next = 1'b0;
          end
        end
      end
      K_CLOSE_WRITER: begin
        if (writers != '0) begin
          writers_next = writers - 1'b1;
          if (writers == END_ONE && readers == '0) begin
            alloc_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    res_next.status           = status;
    res_next.data_out         = '0;
    res_next.fill_level       = fill_next;
    res_next.read_ready       = (fill_next != '0) || (writers_next == '0);
    res_next.write_ready      = (fill_next < FILL_FULL) || (readers_next == '0);
    res_next.hang_up          = (writers_next == '0) && (fill_next == '0);
    res_next.read_would_block = (fill_next == '0) && (writers_next != '0);
    res_next.pipe_in_use      = alloc_next;
    res_next.request_done     = in_data.request_end;
  end

  // ring write and registered read
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      ring[wr_pos] <= in_data.data_in;
    end
    if (accept && mem_re) begin
      rd_data <= ring[rd_pos];
    end
  end

  // advance pipe state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos  <= '0;
      rd_pos  <= '0;
      fill    <= '0;
      readers <= '0;
      writers <= '0;
      alloc   <= 1'b0;
    end else if (accept) begin
      wr_pos  <= wr_pos_next;
      rd_pos  <= rd_pos_next;
      fill    <= fill_next;
      readers <= readers_next;
      writers <= writers_next;
      alloc   <= alloc_next;
    end
  end

  // hold the item's result while the ring read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res   <= res_next;
      s1_rd_ok <= rd_ok_next;
    end
  end

  // merge the popped byte into the held result
  always_comb begin
    s1_out          = s1_res;
    s1_out.data_out = s1_rd_ok ? rd_data : 8'd0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= s1_out;
    end
  end

endmodule

// File: verif/tb_byte_pipe_fifo_with_end_counts.sv
// ----------------------------------------------------------------------------
// tb_byte_pipe_fifo_with_end_counts
// Checks the byte pipe item by item against a behavioral pipe model: a short
// directed table (reset state, error codes, end-count corner cases, reopen),
// an end-count saturation pass, then random pipe traffic. Both sides insert
// random idle cycles per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_byte_pipe_fifo_with_end_counts;
  import bpf_pkg::*;

  localparam int RANDOM_ITEMS = 600;

  typedef struct {
    bit        typed;
    out_item_t want;
  } typed_want_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // pipe model state
  logic [7:0] pm_ring [DEPTH];
  int         pm_wr_ptr;
  int         pm_rd_ptr;
  int         pm_fill;
  int         pm_readers;
  int         pm_writers;
  bit         pm_in_use;

  out_item_t   pending_results[$];
  typed_want_t row_wants[$];
  stim_row_t   stim_rows[$];

  int err_count;
  int results_seen;
  int items_sent;
  bit in_quiet;
  bit out_quiet;

  byte_pipe_fifo_with_end_counts DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous upper bound on the whole run
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 40) begin
      $display("MISMATCH %s at result %0d: got %0d, expected %0d",
               what, results_seen, got, want);
    end
  endtask

  function automatic in_item_t make_item(kind_t k, logic [7:0] d, logic e);
    in_item_t it;
    it.kind        = k;
    it.data_in     = d;
    it.request_end = e;
    return it;
  endfunction

  // result with data_out zero, spelled out flag by flag
  function automatic out_item_t pipe_view(status_t st, int fill, bit rr, bit wr,
                                          bit hu, bit rwb, bit used, bit done);
    out_item_t r;
    r.status           = st;
    r.data_out         = 8'h00;
    r.fill_level       = FILL_W'(fill);
    r.read_ready       = rr;
    r.write_ready      = wr;
    r.hang_up          = hu;
    r.read_would_block = rwb;
    r.pipe_in_use      = used;
    r.request_done     = done;
    return r;
  endfunction

  // advance the pipe model by one item and return its result
  function automatic out_item_t predict_pipe_result(in_item_t it);
    out_item_t r;
    r        = '0;
    r.status = ST_OK;
    case (it.kind)
      K_OPEN: begin
        pm_wr_ptr  = 0;
        pm_rd_ptr  = 0;
        pm_fill    = 0;
        pm_readers = 1;
        pm_writers = 1;
        pm_in_use  = 1'b1;
      end
      K_WRITE: begin
        if (pm_readers == 0) begin
          r.status = ST_BROKEN;
        end else if (pm_fill >= DEPTH) begin
          r.status = ST_BLOCK;
        end else begin
          pm_ring[pm_wr_ptr] = it.data_in;
          pm_wr_ptr = (pm_wr_ptr == DEPTH - 1) ? 0 : pm_wr_ptr + 1;
          pm_fill++;
        end
      end
      K_READ: begin
        if (pm_fill > 0) begin
          r.data_out = pm_ring[pm_rd_ptr];
          pm_rd_ptr  = (pm_rd_ptr == DEPTH - 1) ? 0 : pm_rd_ptr + 1;
          pm_fill--;
        end else if (pm_writers == 0) begin
          r.status = ST_EOF;
        end else begin
          r.status = ST_BLOCK;
        end
      end
      K_ADD_READER: if (pm_readers < MAX_ENDS) pm_readers++;
      K_ADD_WRITER: if (pm_writers < MAX_ENDS) pm_writers++;
      K_CLOSE_READER: begin
        if (pm_readers > 0) begin
          pm_readers--;
          if (pm_readers == 0 && pm_writers == 0) pm_in_use = 1'b0;
        end
      end
      K_CLOSE_WRITER: begin
        if (pm_writers > 0) begin
          pm_writers--;
          if (pm_writers == 0 && pm_readers == 0) pm_in_use = 1'b0;
        end
      end
      default: ;
    endcase
    r.fill_level       = FILL_W'(pm_fill);
    r.read_ready       = (pm_fill > 0) || (pm_writers == 0);
    r.write_ready      = (pm_fill < DEPTH) || (pm_readers == 0);
    r.hang_up          = (pm_writers == 0) && (pm_fill == 0);
    r.read_would_block = (pm_fill == 0) && (pm_writers != 0);
    r.pipe_in_use      = pm_in_use;
    r.request_done     = it.request_end;
    return r;
  endfunction

  task automatic add_row(kind_t k, logic [7:0] d, logic e, bit typed, out_item_t want);
    stim_row_t row;
    row.item  = make_item(k, d, e);
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  // drive one item after a random gap and hold it until the transfer
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int          gap;
    typed_want_t tw;
    gap      = in_quiet ? 0 : $urandom_range(0, 9);
    tw.typed = typed;
    tw.want  = want;
    row_wants.push_back(tw);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (items_sent % 50 == 0) in_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_kind(kind_t k);
    send_item(make_item(k, 8'($urandom), 1'($urandom)), 1'b0, '0);
  endtask

  // output side: random stall before each result, with quiet stretches
  initial begin : result_side
    int hold;
    int taken;
    taken = 0;
    out_stall <= 1'b0;
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 50 == 0) out_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin : watch
    out_item_t   got;
    out_item_t   want;
    typed_want_t tw;
    if (!rst && in_valid && !in_stall) begin
      want = predict_pipe_result(in_data);
      tw   = row_wants.pop_front();
      pending_results.push_back(tw.typed ? tw.want : want);
    end
    if (!rst && out_valid && !out_stall) begin
      got = out_data;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", int'(got.fill_level), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", int'(got.data_out), int'(want.data_out));
        if (got.fill_level !== want.fill_level)
          report_mismatch("fill_level", int'(got.fill_level), int'(want.fill_level));
        if (got.read_ready !== want.read_ready)
          report_mismatch("read_ready", int'(got.read_ready), int'(want.read_ready));
        if (got.write_ready !== want.write_ready)
          report_mismatch("write_ready", int'(got.write_ready), int'(want.write_ready));
        if (got.hang_up !== want.hang_up)
          report_mismatch("hang_up", int'(got.hang_up), int'(want.hang_up));
        if (got.read_would_block !== want.read_would_block)
          report_mismatch("read_would_block", int'(got.read_would_block),
                          int'(want.read_would_block));
        if (got.pipe_in_use !== want.pipe_in_use)
          report_mismatch("pipe_in_use", int'(got.pipe_in_use), int'(want.pipe_in_use));
        if (got.request_done !== want.request_done)
          report_mismatch("request_done", int'(got.request_done), int'(want.request_done));
      end
    end
  end

  initial begin : stimulus
    int   pick;
    int   n;
    kind_t k;

    err_count    = 0;
    results_seen = 0;
    items_sent   = 0;
    in_quiet     = 1'b0;
    out_quiet    = 1'b0;
    pm_wr_ptr    = 0;
    pm_rd_ptr    = 0;
    pm_fill      = 0;
    pm_readers   = 0;
    pm_writers   = 0;
    pm_in_use    = 1'b0;
    for (int i = 0; i < DEPTH; i++) pm_ring[i] = 8'h00;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table: released pipe after reset, open, errors, reopen
    add_row(K_READ,         8'h00, 1'b1, 1'b1, pipe_view(ST_EOF,    0, 1, 1, 1, 0, 0, 1));
    add_row(K_WRITE,        8'hFF, 1'b0, 1'b1, pipe_view(ST_BROKEN, 0, 1, 1, 1, 0, 0, 0));
    add_row(K_CLOSE_READER, 8'h00, 1'b1, 1'b1, pipe_view(ST_OK,     0, 1, 1, 1, 0, 0, 1));
    add_row(K_CLOSE_WRITER, 8'hFF, 1'b0, 1'b1, pipe_view(ST_OK,     0, 1, 1, 1, 0, 0, 0));
    add_row(K_OPEN,         8'h00, 1'b1, 1'b1, pipe_view(ST_OK,     0, 0, 1, 0, 1, 1, 1));
    add_row(K_READ,         8'hFF, 1'b0, 1'b1, pipe_view(ST_BLOCK,  0, 0, 1, 0, 1, 1, 0));
    add_row(K_WRITE,        8'h00, 1'b0, 1'b0, '0);
    add_row(K_WRITE,        8'hFF, 1'b1, 1'b0, '0);
    add_row(K_READ,         8'h00, 1'b0, 1'b0, '0);
    add_row(K_ADD_READER,   8'h00, 1'b0, 1'b0, '0);
    add_row(K_ADD_WRITER,   8'h00, 1'b1, 1'b0, '0);
    add_row(K_CLOSE_WRITER, 8'h00, 1'b0, 1'b0, '0);
    add_row(K_CLOSE_WRITER, 8'h00, 1'b1, 1'b0, '0);
    add_row(K_READ,         8'h00, 1'b0, 1'b0, '0);
    add_row(K_READ,         8'h00, 1'b1, 1'b1, pipe_view(ST_EOF,    0, 1, 1, 1, 0, 1, 1));
    add_row(K_WRITE,        8'hA5, 1'b0, 1'b0, '0);
    add_row(K_CLOSE_READER, 8'h00, 1'b0, 1'b0, '0);
    add_row(K_CLOSE_READER, 8'h00, 1'b1, 1'b0, '0);
    add_row(K_READ,         8'h00, 1'b0, 1'b0, '0);
    add_row(K_WRITE,        8'h3C, 1'b0, 1'b1, pipe_view(ST_BROKEN, 0, 1, 1, 1, 0, 0, 0));
    add_row(K_ADD_WRITER,   8'h00, 1'b1, 1'b0, '0);
    add_row(K_OPEN,         8'h00, 1'b0, 1'b0, '0);
    add_row(K_WRITE,        8'h5A, 1'b0, 1'b0, '0);
    add_row(K_OPEN,         8'hFF, 1'b1, 1'b1, pipe_view(ST_OK,     0, 0, 1, 0, 1, 1, 1));
    add_row(K_READ,         8'h00, 1'b1, 1'b1, pipe_view(ST_BLOCK,  0, 0, 1, 0, 1, 1, 1));
    foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

    // saturate both end counts, then step back from the limit and reopen
    send_kind(K_OPEN);
    repeat (MAX_ENDS + 3) send_kind(K_ADD_READER);
    repeat (MAX_ENDS + 3) send_kind(K_ADD_WRITER);
    send_kind(K_WRITE);
    send_kind(K_CLOSE_READER);
    send_kind(K_CLOSE_WRITER);
    send_kind(K_READ);
    send_kind(K_OPEN);

    // random traffic, mostly pushes and pops on an open pipe
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < (pm_in_use ? 3 : 30))  k = K_OPEN;
      else if (pick < 42)               k = K_WRITE;
      else if (pick < 78)               k = K_READ;
      else if (pick < 84)               k = K_ADD_READER;
      else if (pick < 90)               k = K_ADD_WRITER;
      else if (pick < 95)               k = K_CLOSE_READER;
      else                              k = K_CLOSE_WRITER;
      send_kind(k);
    end

    // drain outstanding results, then allow for the pipeline latency
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
